FILE: hw/rtl/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg: shared types and constants of the vector normalizer
// Widths of the fixed point fields and the records that flow through the
// square root and divider cell chains.
// ----------------------------------------------------------------------------
package vnf_pkg;

	localparam int CompW     = 32;  // component and unit component width
	localparam int SumW      = 64;  // sum of squares width
	localparam int RootW     = 32;  // floor square root of the sum
	localparam int RemW      = 34;  // square root partial remainder
	localparam int QuotW     = 31;  // quotient magnitude, at most 2^30
	localparam int SqrtSteps = SumW / 2;
	localparam int DivSteps  = QuotW;
	localparam int Lanes     = 3;

	localparam logic [SumW-1:0] NormMinSq = SumW'(16);

	// Record carried along the square root chain.
	typedef struct packed {
		logic [RemW-1:0]              rem;
		logic [RootW-1:0]             root;
		logic [SumW-1:0]              x;
		logic [Lanes-1:0][CompW-1:0]  mag;
		logic [Lanes-1:0]             neg;
		logic                         ok;
	} sq_t;

	// Record carried along the divider chain.
	typedef struct packed {
		logic [RootW-1:0]             root;
		logic [Lanes-1:0][RootW-1:0]  r;
		logic [Lanes-1:0]             nb;
		logic [Lanes-1:0][QuotW-1:0]  q;
		logic [Lanes-1:0]             neg;
		logic                         ok;
	} dv_t;

endpackage

FILE: hw/rtl/vnf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vnf_sqrt_cell: one step of the digit-by-digit square root
// Brings down two bits of the radicand and decides one root bit.
// ----------------------------------------------------------------------------
module vnf_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  vnf_pkg::sq_t  in_d,
	output logic          out_v,
	output vnf_pkg::sq_t  out_d
);

	logic [vnf_pkg::RemW+1:0] rem_sh;
	logic [vnf_pkg::RemW+1:0] trial;
	logic                     ge;
	vnf_pkg::sq_t             nxt;
	logic                     v_q;
	vnf_pkg::sq_t             d_q;

	always_comb begin
		rem_sh = {in_d.rem, in_d.x[vnf_pkg::SumW-1 -: 2]};
		trial  = {2'b00, in_d.root, 2'b01};
		ge     = rem_sh >= trial;
		nxt    = in_d;
		nxt.x  = {in_d.x[vnf_pkg::SumW-3:0], 2'b00};
		nxt.root = {in_d.root[vnf_pkg::RootW-2:0], ge};
		if (ge) begin
			nxt.rem = vnf_pkg::RemW'(rem_sh - trial);
		end else begin
			nxt.rem = rem_sh[vnf_pkg::RemW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;

endmodule

FILE: hw/rtl/vnf_div_cell.sv
// ----------------------------------------------------------------------------
// vnf_div_cell: one restoring division step for all three components
// Shifts in one dividend bit per lane and decides one quotient bit.
// ----------------------------------------------------------------------------
module vnf_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  vnf_pkg::dv_t  in_d,
	output logic          out_v,
	output vnf_pkg::dv_t  out_d
);

	logic [vnf_pkg::RootW:0] r_sh;
	logic                    ge;
	vnf_pkg::dv_t            nxt;
	logic                    v_q;
	vnf_pkg::dv_t            d_q;

	always_comb begin
		nxt    = in_d;
		nxt.nb = '0;
		r_sh   = '0;
		ge     = 1'b0;
		for (int i = 0; i < vnf_pkg::Lanes; i++) begin
			r_sh = {in_d.r[i], in_d.nb[i]};
			ge   = r_sh >= {1'b0, in_d.root};
			nxt.q[i] = {in_d.q[i][vnf_pkg::QuotW-2:0], ge};
			if (ge) begin
				nxt.r[i] = vnf_pkg::RootW'(r_sh - {1'b0, in_d.root});
			end else begin
				nxt.r[i] = r_sh[vnf_pkg::RootW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;

endmodule

FILE: hw/rtl/vector3_normalize_fixed.sv
// Throughput: one request per cycle; the whole chain moves as one while the
// output register is free or is being taken, and holds while it is stalled.
// Reset (arst_n low, asynchronous) clears every stage valid bit; the
// data registers are not reset.
// ----------------------------------------------------------------------------
// vector3_normalize_fixed: unit vector of a signed fixed point 3-vector
// Magnitudes, squares and their sum take three stages. The exact floor
// square root of the sum runs down a chain of 32 cells, one root bit per
// cell. Each component shifted left by 30 is then divided by the root in a
// chain of 31 cells, one quotient bit per cell for all three lanes. A final
// register restores the signs and zeroes vectors whose squared norm is
// below 16.
// ----------------------------------------------------------------------------
module vector3_normalize_fixed (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               valid_res,
	output logic signed [31:0] ux,
	output logic signed [31:0] uy,
	output logic signed [31:0] uz
);

	localparam int CW = vnf_pkg::CompW;
	localparam int NL = vnf_pkg::Lanes;

	// The whole chain advances when the output register can take a request.
	logic adv;

	logic [NL-1:0][CW-1:0] comp_in;
	logic [NL-1:0][CW-1:0] mag_s1;
	logic [NL-1:0]         neg_s1;
	logic                  v_s1;
	logic [NL-1:0][vnf_pkg::SumW-1:0] sq_s2;
	logic [NL-1:0][CW-1:0] mag_s2;
	logic [NL-1:0]         neg_s2;
	logic                  v_s2;
	logic [vnf_pkg::SumW-1:0] sum_c;
	vnf_pkg::sq_t          sq_s3;
	logic                  v_s3;

	logic [vnf_pkg::SqrtSteps:0] sqv;
	vnf_pkg::sq_t sqd [vnf_pkg::SqrtSteps+1];
	logic [vnf_pkg::DivSteps:0] dvv;
	vnf_pkg::dv_t dvd [vnf_pkg::DivSteps+1];

	logic               out_v_q;
	logic               ok_q;
	logic [NL-1:0][CW-1:0] unit_q;

	assign adv      = !out_v_q || !out_stall;
	assign in_stall = !adv;
	assign comp_in  = {az, ay, ax};

	// Stage 1: split each component into sign and magnitude.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NL; i++) begin
				neg_s1[i] <= comp_in[i][CW-1];
				mag_s1[i] <= comp_in[i][CW-1] ? CW'(-comp_in[i]) : comp_in[i];
			end
		end
	end

	// Stage 2: one 32 by 32 multiplier per component.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NL; i++) begin
				sq_s2[i] <= {32'd0, mag_s1[i]} * {32'd0, mag_s1[i]};
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: sum of squares; three squares of at most 2^62 never wrap.
	assign sum_c = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3.rem  <= '0;
			sq_s3.root <= '0;
			sq_s3.x    <= sum_c;
			sq_s3.mag  <= mag_s2;
			sq_s3.neg  <= neg_s2;
			sq_s3.ok   <= sum_c >= vnf_pkg::NormMinSq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Square root chain: each cell settles one root bit, most significant first.
	assign sqv[0] = v_s3;
	assign sqd[0] = sq_s3;

	for (genvar k = 0; k < vnf_pkg::SqrtSteps; k++) begin : g_sqrt
		vnf_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.in_v   (sqv[k]),
			.in_d   (sqd[k]),
			.out_v  (sqv[k+1]),
			.out_d  (sqd[k+1])
		);
	end

	// Divider setup. A valid vector has a root of at least every magnitude,
	// so the top 31 dividend bits (magnitude >> 1) start below the root and
	// the quotient fits in 31 bits. The magnitude's low bit enters first.
	always_comb begin
		dvd[0].root = sqd[vnf_pkg::SqrtSteps].root;
		dvd[0].neg  = sqd[vnf_pkg::SqrtSteps].neg;
		dvd[0].ok   = sqd[vnf_pkg::SqrtSteps].ok;
		dvd[0].q    = '0;
		for (int i = 0; i < NL; i++) begin
			dvd[0].r[i]  = {1'b0, sqd[vnf_pkg::SqrtSteps].mag[i][CW-1:1]};
			dvd[0].nb[i] = sqd[vnf_pkg::SqrtSteps].mag[i][0];
		end
	end
	assign dvv[0] = sqv[vnf_pkg::SqrtSteps];

	for (genvar k = 0; k < vnf_pkg::DivSteps; k++) begin : g_div
		vnf_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.in_v   (dvv[k]),
			.in_d   (dvd[k]),
			.out_v  (dvv[k+1]),
			.out_d  (dvd[k+1])
		);
	end

	// Output register: restore signs. A quotient is at most 2^30, so the
	// signed 32-bit result needs no saturation. Short vectors give zeros.
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q <= dvd[vnf_pkg::DivSteps].ok;
			for (int i = 0; i < NL; i++) begin
				if (!dvd[vnf_pkg::DivSteps].ok) begin
					unit_q[i] <= '0;
				end else if (dvd[vnf_pkg::DivSteps].neg[i]) begin
					unit_q[i] <= CW'(-{1'b0, dvd[vnf_pkg::DivSteps].q[i]});
				end else begin
					unit_q[i] <= {1'b0, dvd[vnf_pkg::DivSteps].q[i]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dvv[vnf_pkg::DivSteps];
		end
	end

	assign out_valid = out_v_q;
	assign valid_res = ok_q;
	assign ux        = unit_q[0];
	assign uy        = unit_q[1];
	assign uz        = unit_q[2];

`ifndef NO_ASSERTIONS
	// A short vector always comes out as all zeros.
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> ux == 0 && uy == 0 && uz == 0)
		else $error("short vector gave nonzero components");

	// A unit component never exceeds one in magnitude.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |->
			ux <= 32'sh40000000 && ux >= -32'sh40000000 &&
			uy <= 32'sh40000000 && uy >= -32'sh40000000 &&
			uz <= 32'sh40000000 && uz >= -32'sh40000000)
		else $error("unit component out of range");

	// A valid vector leaves the square root chain with a root of at least 4.
	a_root_min: assert property (@(posedge clk) disable iff (!arst_n)
		sqv[vnf_pkg::SqrtSteps] && sqd[vnf_pkg::SqrtSteps].ok |->
			sqd[vnf_pkg::SqrtSteps].root >= 4)
		else $error("root too small for a valid vector");

	// While the output is stalled the chain holds its last request.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dvv[vnf_pkg::DivSteps]))
		else $error("chain moved under stall");
`endif

endmodule

FILE: verif/tb_vector3_normalize_fixed.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize_fixed: self-checking bench of the vector normalizer
// Random and directed vectors go in through the request channel. A
// scoreboard predicts the unit vector of each accepted request and compares
// it, field by field and in order, with the results that come out.
// ----------------------------------------------------------------------------

// Expected unit vector of one request.
typedef struct packed {
	logic        ok;
	logic [31:0] x;
	logic [31:0] y;
	logic [31:0] z;
} unit_vec_t;

class unit_vec_board;
	unit_vec_t pending[$];
	int        errors;

	function new();
		errors = 0;
	endfunction

	// Exact floor square root, one bit at a time.
	static function logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	static function logic [31:0] scale(logic [31:0] c, logic [63:0] root);
		logic [63:0] m;
		logic [63:0] q;
		m = c[31] ? 64'(-$signed({32'hFFFF_FFFF, c})) : {32'd0, c};
		q = (m << 30) / root;
		if (c[31]) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	// Notes one accepted request and queues the unit vector it must give.
	function void note_request(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		logic [63:0] mx, my, mz, sum, root;
		unit_vec_t   e;
		mx = x[31] ? 64'(-$signed(x)) : {32'd0, x};
		my = y[31] ? 64'(-$signed(y)) : {32'd0, y};
		mz = z[31] ? 64'(-$signed(z)) : {32'd0, z};
		sum = mx * mx + my * my + mz * mz;
		e = '0;
		if (sum >= vnf_pkg::NormMinSq) begin
			root = isqrt(sum);
			if (root == 0) root = 1;
			e.ok = 1'b1;
			e.x = scale(x, root);
			e.y = scale(y, root);
			e.z = scale(z, root);
		end
		pending.push_back(e);
	endfunction

	function void report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endfunction

	// Checks one result against the oldest expectation.
	function void check_result(logic ok, logic [31:0] x, logic [31:0] y,
	                           logic [31:0] z);
		unit_vec_t e;
		if (pending.size() == 0) begin
			report("result with nothing expected, ux", x, 32'd0);
			return;
		end
		e = pending.pop_front();
		if (ok !== e.ok) report("valid_res", 32'(ok), 32'(e.ok));
		if (x !== e.x) report("ux", x, e.x);
		if (y !== e.y) report("uy", y, e.y);
		if (z !== e.z) report("uz", z, e.z);
	endfunction
endclass

module tb_vector3_normalize_fixed;
	localparam int Latency = 67;
	localparam int Watchdog = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] ax = '0;
	logic signed [31:0] ay = '0;
	logic signed [31:0] az = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               valid_res;
	logic signed [31:0] ux, uy, uz;

	unit_vec_board board = new();
	int            idle_cycles = 0;
	// Set by the sender to ask the receiver for one long hold-off.
	logic          hold_req = 1'b0;

	vector3_normalize_fixed i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.ax(ax), .ay(ay), .az(az),
		.out_valid(out_valid), .out_stall(out_stall),
		.valid_res(valid_res), .ux(ux), .uy(uy), .uz(uz)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// Random component: full range, extremes and small values mixed in.
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 8)) - 4);
			3: return 32'($signed($urandom_range(0, 4096)) - 2048);
			default: return $urandom();
		endcase
	endfunction

	// Offers one request and holds it steady until it is taken.
	task automatic send_request(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		ax <= x;
		ay <= y;
		az <= z;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(x, y, z);
	endtask

	// Sends one request, then drops valid for a random gap if one is drawn.
	task automatic send_with_gap(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int g;
		send_request(x, y, z);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_req <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				g = gap_len();
				out_stall <= (g > 0);
				if (g > 1) repeat (g - 1) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Results are sampled at the edge, ahead of the nonblocking updates.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(valid_res, ux, uy, uz);
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= Watchdog) begin
			$display("tb_vector3_normalize_fixed: FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] c;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, the below-threshold edge, extremes and signs.
		send_with_gap(32'd0, 32'd0, 32'd0);
		send_with_gap(32'd3, 32'd0, 32'd0);               // sum 9, too small
		send_with_gap(32'd4, 32'd0, 32'd0);               // sum 16, just valid
		send_with_gap(32'd2, 32'd2, 32'd2);               // sum 12, too small
		send_with_gap(32'd2, 32'd2, -32'sd2);             // still too small
		send_with_gap(32'd3, 32'd2, 32'd2);               // sum 17
		send_with_gap(-32'sd4, 32'd0, 32'd0);
		send_with_gap(32'h8000_0000, 32'd0, 32'd0);
		send_with_gap(32'd0, 32'h8000_0000, 32'd0);
		send_with_gap(32'd0, 32'd0, 32'h8000_0000);
		send_with_gap(32'h7FFF_FFFF, 32'd0, 32'd0);
		send_with_gap(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_with_gap(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_with_gap(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_with_gap(32'h0800_0000, 32'd0, 32'd0);       // 1.0 in F27
		send_with_gap(32'h0800_0000, 32'h0800_0000, 32'h0800_0000);
		send_with_gap(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_with_gap(32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_with_gap(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

		// Random phase, part one.
		repeat (600) send_with_gap(rand_comp(), rand_comp(), rand_comp());

		// Long receiver hold-off while requests keep coming back to back.
		hold_req <= 1'b1;
		repeat (200) send_request(rand_comp(), rand_comp(), rand_comp());

		// Sender pauses until the pipeline has fully drained.
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);

		// Random phase, part two.
		repeat (600) begin
			c = rand_comp();
			send_with_gap(c, rand_comp(), rand_comp());
		end
		in_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_vector3_normalize_fixed: PASS");
		else
			$display("tb_vector3_normalize_fixed: FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/vnf_pkg.sv
hw/rtl/vnf_sqrt_cell.sv
hw/rtl/vnf_div_cell.sv
hw/rtl/vector3_normalize_fixed.sv
verif/tb_vector3_normalize_fixed.sv
